/* rtl/toy_cpu_execute_core_defines.svh */
// Assertion macros for the execute core.
// Depends on nothing; included by the top level.
`ifndef TOY_CPU_EXECUTE_CORE_DEFINES_SVH
`define TOY_CPU_EXECUTE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication under reset
`define TCE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
// next-cycle implication under reset
`define TCE_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define TCE_ASSERT_IMP(label, clk, rst_n, a, b)
`define TCE_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/tce_pkg.sv */
// Shared types, opcodes and helpers of the execute core.
// Depends on nothing.
package tce_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam logic [31:0] PC_HALT_LIMIT = 32'(MEM_BYTES - 3);
    localparam logic [31:0] IRQ_VECTOR    = 32'h0000_8000;
    localparam logic [31:0] SP_RESET      = 32'h0000_FEFF;
    localparam logic [15:0] MASK_RESET    = 16'h0001;

    localparam logic [4:0] OP_LB   = 5'd0;
    localparam logic [4:0] OP_LH   = 5'd1;
    localparam logic [4:0] OP_LW   = 5'd2;
    localparam logic [4:0] OP_SB   = 5'd3;
    localparam logic [4:0] OP_SH   = 5'd4;
    localparam logic [4:0] OP_SW   = 5'd5;
    localparam logic [4:0] OP_PUSH = 5'd6;
    localparam logic [4:0] OP_POP  = 5'd7;
    localparam logic [4:0] OP_JMP  = 5'd8;
    localparam logic [4:0] OP_WFI  = 5'd9;
    localparam logic [4:0] OP_MSET = 5'd10;
    localparam logic [4:0] OP_MGET = 5'd11;
    localparam logic [4:0] OP_PSET = 5'd12;
    localparam logic [4:0] OP_PGET = 5'd13;
    localparam logic [4:0] OP_HALT = 5'd14;
    localparam logic [4:0] OP_NOP  = 5'd15;
    localparam logic [4:0] OP_ADC  = 5'd16;
    localparam logic [4:0] OP_SBC  = 5'd17;
    localparam logic [4:0] OP_CMP  = 5'd18;
    localparam logic [4:0] OP_AND  = 5'd19;
    localparam logic [4:0] OP_OR   = 5'd20;
    localparam logic [4:0] OP_NOT  = 5'd21;
    localparam logic [4:0] OP_SHR  = 5'd22;
    localparam logic [4:0] OP_SHL  = 5'd23;
    localparam logic [4:0] OP_SAR  = 5'd24;
    localparam logic [4:0] OP_ROR  = 5'd25;

    localparam logic [1:0] MODE_REG   = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd1;
    localparam logic [1:0] MODE_LONG  = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    localparam logic [2:0] REG_ZERO = 3'd0;
    localparam logic [2:0] REG_SP   = 3'd6;
    localparam logic [2:0] REG_PC   = 3'd7;

    // decoded request as it travels from front to back
    typedef struct packed {
        logic        req_type;
        logic [4:0]  opcode;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg_a;
        logic [2:0]  src_reg_b;
        logic        use_imm;
        logic        fault;
        logic        step4;
        logic [1:0]  mem_last;
        logic [31:0] imm_value;
        logic [3:0]  interrupt_line;
    } tce_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        halted;
        logic        took_interrupt;
        logic        waiting;
        logic        reg_written;
        logic [2:0]  written_reg;
        logic [31:0] written_value;
    } tce_result_t;

    // set or clear one bit of a 16-bit control word
    function automatic logic [15:0] bit_update(logic [15:0] word, logic [31:0] idx, logic on);
        logic [15:0] sel;
        sel = 16'(1) << idx[3:0];
        if (idx[31:4] != '0)
            return word;
        return on ? (word | sel) : (word & ~sel);
    endfunction

    function automatic logic [31:0] bit_read(logic [15:0] word, logic [31:0] idx);
        if (idx[31:4] != '0)
            return '0;
        return {31'd0, word[idx[3:0]]};
    endfunction

endpackage

/* rtl/tce_front.sv */
// Front stage: registers an incoming request and decodes operand form and access size.
// Depends on tce_pkg.
module tce_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                req_type,
    input  logic [4:0]          opcode,
    input  logic [2:0]          dest_reg,
    input  logic [2:0]          src_reg_a,
    input  logic [2:0]          src_reg_b,
    input  logic [1:0]          operand_mode,
    input  logic [15:0]         immediate,
    input  logic [3:0]          interrupt_line,
    input  logic                clearing,
    input  logic                q_full,
    output logic                q_push,
    output tce_pkg::tce_item_t  q_item
);

    logic               vld_reg;
    tce_pkg::tce_item_t item_reg;
    tce_pkg::tce_item_t item_next;
    logic               accept;

    assign full   = clearing | (vld_reg & q_full);
    assign accept = push & ~full;
    assign q_push = vld_reg & ~q_full;
    assign q_item = item_reg;

    // decode operand source and access size
    always_comb
    begin
        item_next.req_type       = req_type;
        item_next.opcode         = opcode;
        item_next.dest_reg       = dest_reg;
        item_next.src_reg_a      = src_reg_a;
        item_next.src_reg_b      = src_reg_b;
        item_next.interrupt_line = interrupt_line;
        item_next.use_imm        = (operand_mode == tce_pkg::MODE_SHORT) ||
                                   (operand_mode == tce_pkg::MODE_LONG);
        item_next.fault          = (operand_mode == tce_pkg::MODE_FAULT);
        item_next.step4          = (operand_mode == tce_pkg::MODE_LONG);
        if (operand_mode == tce_pkg::MODE_LONG)
            item_next.imm_value = {{16{immediate[15]}}, immediate};
        else
            item_next.imm_value = {{29{src_reg_b[2]}}, src_reg_b};
        unique case (opcode)
            tce_pkg::OP_LB, tce_pkg::OP_SB: item_next.mem_last = 2'd0;
            tce_pkg::OP_LH, tce_pkg::OP_SH: item_next.mem_last = 2'd1;
            default:                         item_next.mem_last = 2'd3;
        endcase
    end

    // hold one decoded request until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (q_push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/tce_queue.sv */
// Two-entry queue of decoded requests between front and back.
// Depends on tce_pkg.
module tce_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tce_pkg::tce_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output tce_pkg::tce_item_t head
);

    tce_pkg::tce_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/tce_back.sv */
// Back stage: architectural state, data memory sequencer and result queue.
// Depends on tce_pkg.
module tce_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  tce_pkg::tce_item_t q_head,
    output logic               q_pop,
    output logic               clearing,
    output logic               empty,
    input  logic               pop,
    output tce_pkg::tce_result_t result
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MEM   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [31:0] rf_mem [8];
    logic [7:0]  rf_valid_reg;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] pc_reg, pc_next;
    logic        carry_reg, carry_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] pend_reg, pend_next;
    logic        wait_reg, wait_next;
    logic        halt_reg, halt_next;

    // current request and operand reads
    tce_pkg::tce_item_t cur_reg;
    logic [31:0] ra_data_reg, rb_data_reg;
    logic        ra_ok_reg, rb_ok_reg;
    logic [31:0] v1, v2;

    // memory and its sequencer
    logic [7:0]  dmem [tce_pkg::MEM_BYTES];
    logic [7:0]  mem_rdata_reg;
    logic [tce_pkg::MEM_AW-1:0] clr_addr_reg;
    logic [31:0] maddr_reg, mwdata_reg, macc_reg;
    logic [2:0]  mcnt_reg;
    logic [1:0]  mcap_reg, mlast_reg;
    logic        mwr_reg, mpend_reg, irq_reg;
    logic        mem_we;
    logic [tce_pkg::MEM_AW-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic [31:0] mem_a;
    logic        issue, mem_fin;

    logic        mem_go, mem_wr_go, irq_go;
    logic [31:0] mem_addr_go, mem_wdata_go;

    // writeback tail
    logic        t_run, t_store, t_pcset;
    logic [31:0] t_res;
    logic        rf_we;
    logic [31:0] rf_wd;
    logic        res_push, took, wrote;
    logic [2:0]  wreg;
    logic [31:0] wval, pc_adv;
    logic [32:0] sum33;
    logic [4:0]  sh;

    // result queue
    tce_pkg::tce_result_t rq_reg [2];
    tce_pkg::tce_result_t res_item;
    logic        rq_wr_reg, rq_rd_reg;
    logic [1:0]  rq_count_reg;
    logic        rq_pop;

    assign clearing = (state_reg == S_CLEAR);
    assign empty    = (rq_count_reg == 2'd0);
    assign result   = rq_reg[rq_rd_reg];
    assign rq_pop   = pop & ~empty;

    // operand select
    always_comb
    begin
        if (cur_reg.src_reg_a == tce_pkg::REG_SP)
            v1 = sp_reg;
        else if (cur_reg.src_reg_a == tce_pkg::REG_PC)
            v1 = pc_reg;
        else
            v1 = ra_ok_reg ? ra_data_reg : '0;
        if (cur_reg.use_imm)
            v2 = cur_reg.imm_value;
        else if (cur_reg.src_reg_b == tce_pkg::REG_SP)
            v2 = sp_reg;
        else if (cur_reg.src_reg_b == tce_pkg::REG_PC)
            v2 = pc_reg;
        else
            v2 = rb_ok_reg ? rb_data_reg : '0;
    end

    assign sh = v2[4:0];

    // byte sequencer
    assign mem_a   = maddr_reg + 32'(mcnt_reg);
    assign issue   = (state_reg == S_MEM) && (mcnt_reg <= {1'b0, mlast_reg});
    assign mem_fin = mwr_reg ? (issue && (mcnt_reg[1:0] == mlast_reg))
                             : (mpend_reg && (mcap_reg == mlast_reg));

    always_comb
    begin
        if (clearing)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = 8'd0;
        end
        else
        begin
            mem_we = issue & mwr_reg;
            mem_wa = mem_a[tce_pkg::MEM_AW-1:0];
            mem_wd = mwdata_reg[8*mcnt_reg[1:0] +: 8];
        end
        mem_ra = mem_a[tce_pkg::MEM_AW-1:0];
    end

    // execute and retire
    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        pc_next      = pc_reg;
        carry_next   = carry_reg;
        mask_next    = mask_reg;
        pend_next    = pend_reg;
        wait_next    = wait_reg;
        halt_next    = halt_reg;
        q_pop        = 1'b0;
        mem_go       = 1'b0;
        mem_wr_go    = 1'b0;
        irq_go       = 1'b0;
        mem_addr_go  = v1;
        mem_wdata_go = v2;
        t_run        = 1'b0;
        t_store      = 1'b0;
        t_pcset      = 1'b0;
        t_res        = '0;
        rf_we        = 1'b0;
        rf_wd        = '0;
        res_push     = 1'b0;
        took         = 1'b0;
        wrote        = 1'b0;
        wreg         = '0;
        wval         = '0;
        sum33        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (&clr_addr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty && (rq_count_reg != 2'd2))
                begin
                    q_pop      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (halt_reg)
                begin
                    res_push = 1'b1;
                end
                else if (cur_reg.req_type)
                begin
                    pend_next = pend_reg | (16'(1) << cur_reg.interrupt_line);
                    res_push  = 1'b1;
                end
                else if (|(mask_reg & pend_reg))
                begin
                    mem_go       = 1'b1;
                    mem_wr_go    = 1'b1;
                    irq_go       = 1'b1;
                    mem_addr_go  = sp_reg;
                    mem_wdata_go = pc_reg;
                end
                else if (wait_reg)
                begin
                    res_push = 1'b1;
                end
                else if (cur_reg.fault)
                begin
                    pend_next = pend_reg | 16'h0001;
                    t_run     = 1'b1;
                end
                else
                begin
                    case (cur_reg.opcode)
                        tce_pkg::OP_LB, tce_pkg::OP_LH, tce_pkg::OP_LW:
                        begin
                            mem_go = 1'b1;
                        end
                        tce_pkg::OP_SB, tce_pkg::OP_SH, tce_pkg::OP_SW:
                        begin
                            mem_go    = 1'b1;
                            mem_wr_go = 1'b1;
                        end
                        tce_pkg::OP_PUSH:
                        begin
                            mem_go      = 1'b1;
                            mem_wr_go   = 1'b1;
                            mem_addr_go = sp_reg;
                        end
                        tce_pkg::OP_POP:
                        begin
                            mem_go      = 1'b1;
                            mem_addr_go = sp_reg + 32'd4;
                        end
                        tce_pkg::OP_JMP:
                        begin
                            t_run = 1'b1;
                            if (v1 != '0)
                            begin
                                pc_next = v2;
                                t_pcset = 1'b1;
                            end
                        end
                        tce_pkg::OP_WFI:
                        begin
                            wait_next = 1'b1;
                            t_run     = 1'b1;
                        end
                        tce_pkg::OP_MSET:
                        begin
                            mask_next = tce_pkg::bit_update(mask_reg, v1, v2 != '0);
                            t_run     = 1'b1;
                        end
                        tce_pkg::OP_MGET:
                        begin
                            t_res   = tce_pkg::bit_read(mask_reg, v1);
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_PSET:
                        begin
                            pend_next = tce_pkg::bit_update(pend_reg, v1, v2 != '0);
                            t_run     = 1'b1;
                        end
                        tce_pkg::OP_PGET:
                        begin
                            t_res   = tce_pkg::bit_read(pend_reg, v1);
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_HALT:
                        begin
                            halt_next = 1'b1;
                            t_pcset   = 1'b1;
                            t_run     = 1'b1;
                        end
                        tce_pkg::OP_NOP:
                        begin
                            t_run = 1'b1;
                        end
                        tce_pkg::OP_ADC:
                        begin
                            sum33      = {1'b0, v1} + {1'b0, v2} + 33'(carry_reg);
                            t_res      = sum33[31:0];
                            carry_next = sum33[32];
                            t_store    = 1'b1;
                            t_run      = 1'b1;
                        end
                        tce_pkg::OP_SBC:
                        begin
                            sum33      = {1'b0, v1} + {1'b0, ~v2} + {32'd0, ~carry_reg};
                            t_res      = sum33[31:0];
                            carry_next = sum33[32];
                            t_store    = 1'b1;
                            t_run      = 1'b1;
                        end
                        tce_pkg::OP_CMP:
                        begin
                            if (v1 > v2)
                                t_res = 32'd1;
                            else if (v1 == v2)
                                t_res = 32'd0;
                            else
                                t_res = '1;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_AND:
                        begin
                            t_res   = v1 & v2;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_OR:
                        begin
                            t_res   = v1 | v2;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_NOT:
                        begin
                            t_res   = ~v1;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_SHR:
                        begin
                            t_res   = v1 >> sh;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_SHL:
                        begin
                            t_res   = v1 << sh;
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_SAR:
                        begin
                            t_res   = 32'($signed(v1) >>> sh);
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        tce_pkg::OP_ROR:
                        begin
                            t_res   = 32'({v1, v1} >> sh);
                            t_store = 1'b1;
                            t_run   = 1'b1;
                        end
                        default:
                        begin
                            // undefined opcode: flag fault, write zero
                            pend_next = pend_reg | 16'h0001;
                            t_store   = 1'b1;
                            t_run     = 1'b1;
                        end
                    endcase
                end
                if (mem_go)
                    state_next = S_MEM;
                else if (!t_run)
                    state_next = S_IDLE;
            end
            S_MEM:
            begin
                if (mem_fin)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (irq_reg)
                begin
                    sp_next   = sp_reg - 32'd4;
                    pc_next   = tce_pkg::IRQ_VECTOR;
                    wait_next = 1'b0;
                    took      = 1'b1;
                    res_push  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (cur_reg.opcode == tce_pkg::OP_PUSH)
                        sp_next = sp_reg - 32'd4;
                    else if (cur_reg.opcode == tce_pkg::OP_POP)
                        sp_next = sp_reg + 32'd4;
                    t_store = !mwr_reg;
                    t_res   = macc_reg;
                    t_run   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writeback and PC advance
        pc_adv = pc_reg + (cur_reg.step4 ? 32'd4 : 32'd2);
        if (t_run)
        begin
            res_push   = 1'b1;
            state_next = S_IDLE;
            if (t_store && (cur_reg.dest_reg != tce_pkg::REG_ZERO))
            begin
                wrote = 1'b1;
                wreg  = cur_reg.dest_reg;
                wval  = t_res;
                if (cur_reg.dest_reg == tce_pkg::REG_SP)
                begin
                    sp_next = t_res;
                end
                else if (cur_reg.dest_reg == tce_pkg::REG_PC)
                begin
                    pc_next = t_res;
                    t_pcset = 1'b1;
                end
                else
                begin
                    rf_we = 1'b1;
                    rf_wd = t_res;
                end
            end
            if (!t_pcset)
            begin
                pc_next = pc_adv;
                if (pc_adv >= tce_pkg::PC_HALT_LIMIT)
                    halt_next = 1'b1;
            end
        end

        res_item.next_pc        = pc_next[15:0];
        res_item.halted         = halt_next;
        res_item.took_interrupt = took;
        res_item.waiting        = wait_next;
        res_item.reg_written    = wrote;
        res_item.written_reg    = wreg;
        res_item.written_value  = wval;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            rf_valid_reg <= '0;
            sp_reg       <= tce_pkg::SP_RESET;
            pc_reg       <= '0;
            carry_reg    <= 1'b0;
            mask_reg     <= tce_pkg::MASK_RESET;
            pend_reg     <= '0;
            wait_reg     <= 1'b0;
            halt_reg     <= 1'b0;
            mcnt_reg     <= '0;
            mcap_reg     <= '0;
            mpend_reg    <= 1'b0;
            rq_wr_reg    <= 1'b0;
            rq_rd_reg    <= 1'b0;
            rq_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            pc_reg    <= pc_next;
            carry_reg <= carry_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
            wait_reg  <= wait_next;
            halt_reg  <= halt_next;
            if (clearing)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (rf_we)
                rf_valid_reg[cur_reg.dest_reg] <= 1'b1;
            // step byte counters
            if (mem_go)
            begin
                mcnt_reg  <= '0;
                mcap_reg  <= '0;
                mpend_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                    mcnt_reg <= mcnt_reg + 3'd1;
                mpend_reg <= issue & ~mwr_reg;
                if (mpend_reg)
                    mcap_reg <= mcap_reg + 2'd1;
            end
            // result queue pointers
            if (res_push)
                rq_wr_reg <= ~rq_wr_reg;
            if (rq_pop)
                rq_rd_reg <= ~rq_rd_reg;
            if (res_push && !rq_pop)
                rq_count_reg <= rq_count_reg + 2'd1;
            else if (rq_pop && !res_push)
                rq_count_reg <= rq_count_reg - 2'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg     <= q_head;
            ra_data_reg <= rf_mem[q_head.src_reg_a];
            rb_data_reg <= rf_mem[q_head.src_reg_b];
            ra_ok_reg   <= rf_valid_reg[q_head.src_reg_a];
            rb_ok_reg   <= rf_valid_reg[q_head.src_reg_b];
        end
        if (rf_we)
            rf_mem[cur_reg.dest_reg] <= rf_wd;
        if (mem_go)
        begin
            maddr_reg  <= mem_addr_go;
            mwdata_reg <= mem_wdata_go;
            mwr_reg    <= mem_wr_go;
            mlast_reg  <= irq_go ? 2'd3 : cur_reg.mem_last;
            irq_reg    <= irq_go;
            macc_reg   <= '0;
        end
        else if (mpend_reg)
        begin
            macc_reg[8*mcap_reg +: 8] <= mem_rdata_reg;
        end
        if (res_push)
            rq_reg[rq_wr_reg] <= res_item;
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            dmem[mem_wa] <= mem_wd;
        mem_rdata_reg <= dmem[mem_ra];
    end

endmodule

/* rtl/toy_cpu_execute_core.sv */
// Top level of the execute core: front decode, request queue and back stage.
// Depends on tce_pkg, tce_front, tce_queue, tce_back and the defines header.
//
//  channel   handshake     payload
//  request   push / full   req_type opcode dest_reg src_reg_a src_reg_b
//                          operand_mode immediate interrupt_line
//  result    empty / pop   next_pc halted took_interrupt waiting
//                          reg_written written_reg written_value
//
// A register or ALU request passes through the IDLE and EXEC states of the back
// stage; a memory access also passes through MEM and DONE, moving one byte at a
// time (up to 4 bytes) through the byte-wide port of the data memory.
// After reset the whole data memory is cleared to zero; full stays high meanwhile.
// The front holds one request and the queue two more, so requests keep coming
// while results wait; the back stalls only when two results are unread.
`include "toy_cpu_execute_core_defines.svh"
module toy_cpu_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [4:0]  opcode,
    input  logic [2:0]  dest_reg,
    input  logic [2:0]  src_reg_a,
    input  logic [2:0]  src_reg_b,
    input  logic [1:0]  operand_mode,
    input  logic [15:0] immediate,
    input  logic [3:0]  interrupt_line,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] next_pc,
    output logic        halted,
    output logic        took_interrupt,
    output logic        waiting,
    output logic        reg_written,
    output logic [2:0]  written_reg,
    output logic [31:0] written_value
);

    logic                 clearing;
    logic                 q_full, q_push, q_pop, q_empty;
    tce_pkg::tce_item_t   q_in, q_head;
    tce_pkg::tce_result_t res;

    tce_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .opcode         (opcode),
        .dest_reg       (dest_reg),
        .src_reg_a      (src_reg_a),
        .src_reg_b      (src_reg_b),
        .operand_mode   (operand_mode),
        .immediate      (immediate),
        .interrupt_line (interrupt_line),
        .clearing       (clearing),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in)
    );

    tce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    tce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .result   (res)
    );

    assign next_pc        = res.next_pc;
    assign halted         = res.halted;
    assign took_interrupt = res.took_interrupt;
    assign waiting        = res.waiting;
    assign reg_written    = res.reg_written;
    assign written_reg    = res.written_reg;
    assign written_value  = res.written_value;

    // no results and no requests taken while the memory is being cleared
    `TCE_ASSERT_IMP(a_clear_no_result, clk, rst_n, clearing, empty && full)
    // interrupt entry never reports a register write
    `TCE_ASSERT_IMP(a_irq_no_write, clk, rst_n, !empty && took_interrupt, !reg_written)
    // the back never pops an empty queue
    `TCE_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, !q_empty)
    // a request pushed into the queue with no pop at the same time leaves it non-empty
    `TCE_ASSERT_NXT(a_queue_holds, clk, rst_n, q_push && !q_pop, !q_empty)

endmodule

/* bench/toy_cpu_execute_core_tb.sv */
// Testbench for toy_cpu_execute_core: directed table, then constrained-by-state random requests.
// Depends on tce_pkg and the execute core RTL; results are checked against an in-bench model.
`timescale 1ns / 1ps
module toy_cpu_execute_core_tb;
    import tce_pkg::*;

    localparam logic REQ_EXEC  = 1'b0;
    localparam logic REQ_RAISE = 1'b1;
    localparam logic [4:0] OP_BAD_FIRST = 5'd26;
    localparam logic [4:0] OP_BAD_LAST  = 5'd31;
    localparam int RANDOM_REQS = 850;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        rt;
        logic [4:0]  op;
        logic [2:0]  rd;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [1:0]  mode;
        logic [15:0] imm;
        logic [3:0]  line;
    } cpu_req_t;

    typedef struct packed {
        cpu_req_t    r;
        logic        typed;
        tce_result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        req_type = 1'b0;
    logic [4:0]  opcode = '0;
    logic [2:0]  dest_reg = '0;
    logic [2:0]  src_reg_a = '0;
    logic [2:0]  src_reg_b = '0;
    logic [1:0]  operand_mode = '0;
    logic [15:0] immediate = '0;
    logic [3:0]  interrupt_line = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] next_pc;
    logic        halted;
    logic        took_interrupt;
    logic        waiting;
    logic        reg_written;
    logic [2:0]  written_reg;
    logic [31:0] written_value;

    // mirrored CPU state
    logic [31:0] cpu_regs [8];
    logic [7:0]  data_mem [MEM_BYTES];
    logic        carry_flag;
    logic [15:0] irq_mask;
    logic [15:0] irq_pending;
    logic        wait_state;
    logic        halt_state;

    tce_result_t pending_results [$];
    dir_row_t    dir_rows [$];
    int          errors = 0;
    int          traffic = 0;
    bit          hold_go = 0;
    int          hold_cnt = 0;
    int          idle_cnt = 0;

    toy_cpu_execute_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .opcode(opcode), .dest_reg(dest_reg),
        .src_reg_a(src_reg_a), .src_reg_b(src_reg_b), .operand_mode(operand_mode),
        .immediate(immediate), .interrupt_line(interrupt_line),
        .empty(empty), .pop(pop), .next_pc(next_pc), .halted(halted),
        .took_interrupt(took_interrupt), .waiting(waiting), .reg_written(reg_written),
        .written_reg(written_reg), .written_value(written_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] operand_b(cpu_req_t r);
        if (r.mode == MODE_REG)
            return cpu_regs[r.rb];
        if (r.mode == MODE_SHORT)
            return {{29{r.rb[2]}}, r.rb};
        if (r.mode == MODE_LONG)
            return {{16{r.imm[15]}}, r.imm};
        return '0;
    endfunction

    function automatic logic [31:0] mem_load(logic [31:0] addr, int nbytes);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < nbytes; i++)
            v[8*i +: 8] = data_mem[16'(addr + i)];
        return v;
    endfunction

    function automatic void mem_store(logic [31:0] addr, logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++)
            data_mem[16'(addr + i)] = v[8*i +: 8];
    endfunction

    // apply one request to the mirrored state and return its result
    function automatic tce_result_t execute_req(cpu_req_t r);
        tce_result_t res;
        logic [31:0] v1, v2, val;
        logic [32:0] wide;
        logic [4:0]  sh;
        logic [2:0]  step;
        logic        store, pc_set;
        res = '0;
        if (halt_state) begin
        end else if (r.rt == REQ_RAISE) begin
            irq_pending[r.line] = 1'b1;
        end else if ((irq_mask & irq_pending) != 0) begin
            mem_store(cpu_regs[REG_SP], cpu_regs[REG_PC], 4);
            cpu_regs[REG_SP] -= 4;
            cpu_regs[REG_PC] = IRQ_VECTOR;
            wait_state = 1'b0;
            res.took_interrupt = 1'b1;
        end else if (!wait_state) begin
            v1 = cpu_regs[r.ra];
            v2 = operand_b(r);
            sh = v2[4:0];
            step = (r.mode == MODE_LONG) ? 3'd4 : 3'd2;
            val = '0;
            store = 1'b0;
            pc_set = 1'b0;
            if (r.mode == MODE_FAULT) begin
                irq_pending[0] = 1'b1;
            end else begin
                case (r.op)
                    OP_LB: begin val = mem_load(v1, 1); store = 1'b1; end
                    OP_LH: begin val = mem_load(v1, 2); store = 1'b1; end
                    OP_LW: begin val = mem_load(v1, 4); store = 1'b1; end
                    OP_SB: mem_store(v1, v2, 1);
                    OP_SH: mem_store(v1, v2, 2);
                    OP_SW: mem_store(v1, v2, 4);
                    OP_PUSH: begin
                        mem_store(cpu_regs[REG_SP], v2, 4);
                        cpu_regs[REG_SP] -= 4;
                    end
                    OP_POP: begin
                        cpu_regs[REG_SP] += 4;
                        val = mem_load(cpu_regs[REG_SP], 4);
                        store = 1'b1;
                    end
                    OP_JMP: if (v1 != 0) begin cpu_regs[REG_PC] = v2; pc_set = 1'b1; end
                    OP_WFI: wait_state = 1'b1;
                    OP_MSET: if (v1 < 16) irq_mask[v1[3:0]] = (v2 != 0);
                    OP_MGET: begin val = (v1 < 16) ? irq_mask[v1[3:0]] : 0; store = 1'b1; end
                    OP_PSET: if (v1 < 16) irq_pending[v1[3:0]] = (v2 != 0);
                    OP_PGET: begin val = (v1 < 16) ? irq_pending[v1[3:0]] : 0; store = 1'b1; end
                    OP_HALT: begin halt_state = 1'b1; pc_set = 1'b1; end
                    OP_NOP: ;
                    OP_ADC: begin
                        wide = {1'b0, v1} + {1'b0, v2} + carry_flag;
                        val = wide[31:0]; carry_flag = wide[32]; store = 1'b1;
                    end
                    OP_SBC: begin
                        wide = {1'b0, v1} + {1'b0, ~v2} + !carry_flag;
                        val = wide[31:0]; carry_flag = wide[32]; store = 1'b1;
                    end
                    OP_CMP: begin
                        val = (v1 > v2) ? 32'd1 : ((v1 == v2) ? 32'd0 : 32'hFFFF_FFFF);
                        store = 1'b1;
                    end
                    OP_AND: begin val = v1 & v2; store = 1'b1; end
                    OP_OR:  begin val = v1 | v2; store = 1'b1; end
                    OP_NOT: begin val = ~v1; store = 1'b1; end
                    OP_SHR: begin val = v1 >> sh; store = 1'b1; end
                    OP_SHL: begin val = v1 << sh; store = 1'b1; end
                    OP_SAR: begin val = $unsigned($signed(v1) >>> sh); store = 1'b1; end
                    OP_ROR: begin val = (v1 >> sh) | (v1 << (6'd32 - sh)); store = 1'b1; end
                    default: begin val = '0; irq_pending[0] = 1'b1; store = 1'b1; end
                endcase
            end
            if (store && r.rd != REG_ZERO) begin
                cpu_regs[r.rd] = val;
                res.reg_written = 1'b1;
                res.written_reg = r.rd;
                res.written_value = val;
                if (r.rd == REG_PC)
                    pc_set = 1'b1;
            end
            if (!pc_set) begin
                cpu_regs[REG_PC] += step;
                if (cpu_regs[REG_PC] >= PC_HALT_LIMIT)
                    halt_state = 1'b1;
            end
        end
        res.next_pc = cpu_regs[REG_PC][15:0];
        res.halted = halt_state;
        res.waiting = wait_state;
        return res;
    endfunction

    // true when a request would start an endless interrupt entry, a wait or a halt
    function automatic bit locks_up(cpu_req_t r);
        logic [31:0] v1, v2;
        v1 = cpu_regs[r.ra];
        v2 = operand_b(r);
        if (r.rt == REQ_RAISE)
            return irq_mask[r.line];
        if (r.mode == MODE_FAULT || r.op >= OP_BAD_FIRST)
            return irq_mask[0];
        if (r.op == OP_WFI || r.op == OP_HALT)
            return 1;
        if (r.op == OP_MSET && v1 < 16 && v2 != 0)
            return irq_pending[v1[3:0]];
        if (r.op == OP_PSET && v1 < 16 && v2 != 0)
            return irq_mask[v1[3:0]];
        return 0;
    endfunction

    function automatic cpu_req_t random_req();
        cpu_req_t r;
        do begin
            r.rt = ($urandom_range(0, 99) < 8) ? REQ_RAISE : REQ_EXEC;
            r.op = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST))
                                               : 5'($urandom_range(OP_LB, OP_ROR));
            r.rd = 3'($urandom);
            r.ra = 3'($urandom);
            r.rb = 3'($urandom);
            r.mode = ($urandom_range(0, 99) < 4) ? MODE_FAULT : 2'($urandom_range(0, 2));
            r.imm = 16'($urandom);
            r.line = 4'($urandom);
        end while (locks_up(r));
        return r;
    endfunction

    function automatic cpu_req_t mk(logic rt, logic [4:0] op, logic [2:0] rd, logic [2:0] ra,
                                    logic [2:0] rb, logic [1:0] mode, logic [15:0] imm,
                                    logic [3:0] line);
        cpu_req_t r;
        r.rt = rt; r.op = op; r.rd = rd; r.ra = ra; r.rb = rb;
        r.mode = mode; r.imm = imm; r.line = line;
        return r;
    endfunction

    task automatic add_row(cpu_req_t r, logic typed, tce_result_t want);
        dir_row_t row;
        row.r = r; row.typed = typed; row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic tce_result_t mk_res(logic [15:0] pc, logic wr, logic [2:0] wreg,
                                           logic [31:0] wval);
        tce_result_t res;
        res = '0;
        res.next_pc = pc; res.reg_written = wr; res.written_reg = wreg; res.written_value = wval;
        return res;
    endfunction

    // offer one request, hold it until taken, then record its expected result
    task automatic send_req(cpu_req_t r, logic typed, tce_result_t want);
        int idle_pct;
        tce_result_t got;
        idle_pct = (traffic == 1) ? 79 : ((traffic == 3) ? 31 : 0);
        if ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        req_type <= r.rt; opcode <= r.op; dest_reg <= r.rd; src_reg_a <= r.ra;
        src_reg_b <= r.rb; operand_mode <= r.mode; immediate <= r.imm;
        interrupt_line <= r.line;
        @(posedge clk);
        while (full)
            @(posedge clk);
        got = execute_req(r);
        pending_results.push_back(typed ? want : got);
    endtask

    // receive results and compare field by field
    initial
    begin
        tce_result_t exp_res;
        int stall_pct;
        forever
        begin
            @(posedge clk);
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, next_pc %h", $time, next_pc);
                    errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (next_pc !== exp_res.next_pc) begin
                        $display("%0t: next_pc exp %h got %h", $time, exp_res.next_pc, next_pc);
                        errors++;
                    end
                    if (halted !== exp_res.halted) begin
                        $display("%0t: halted exp %b got %b", $time, exp_res.halted, halted);
                        errors++;
                    end
                    if (took_interrupt !== exp_res.took_interrupt) begin
                        $display("%0t: took_interrupt exp %b got %b", $time,
                                 exp_res.took_interrupt, took_interrupt);
                        errors++;
                    end
                    if (waiting !== exp_res.waiting) begin
                        $display("%0t: waiting exp %b got %b", $time, exp_res.waiting, waiting);
                        errors++;
                    end
                    if (reg_written !== exp_res.reg_written) begin
                        $display("%0t: reg_written exp %b got %b", $time,
                                 exp_res.reg_written, reg_written);
                        errors++;
                    end
                    if (written_reg !== exp_res.written_reg) begin
                        $display("%0t: written_reg exp %0d got %0d", $time,
                                 exp_res.written_reg, written_reg);
                        errors++;
                    end
                    if (written_value !== exp_res.written_value) begin
                        $display("%0t: written_value exp %h got %h", $time,
                                 exp_res.written_value, written_value);
                        errors++;
                    end
                end
            end
            // hold off for a long stretch when asked, else stall at random
            if (hold_go) begin
                hold_go = 0;
                hold_cnt = HOLD_CYCLES;
            end
            stall_pct = (traffic == 2) ? 79 : ((traffic == 3) ? 31 : 0);
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cpu_req_t r;
        tce_result_t none;
        none = '0;
        foreach (data_mem[i])
            data_mem[i] = 8'h00;
        foreach (cpu_regs[i])
            cpu_regs[i] = '0;
        cpu_regs[REG_SP] = SP_RESET;
        carry_flag = 1'b0;
        irq_mask = MASK_RESET;
        irq_pending = '0;
        wait_state = 1'b0;
        halt_state = 1'b0;

        // directed table: mask off line 0 first so faults do not trap
        add_row(mk(REQ_EXEC, OP_MSET, 3'd0, 3'd0, 3'd0, MODE_SHORT, 16'h0000, 4'd0), 1,
                mk_res(16'd2, 0, 3'd0, 32'd0));
        add_row(mk(REQ_EXEC, OP_ADC, 3'd1, 3'd0, 3'd0, MODE_LONG, 16'hFFFF, 4'd0), 1,
                mk_res(16'd6, 1, 3'd1, 32'hFFFF_FFFF));
        add_row(mk(REQ_EXEC, OP_ADC, 3'd2, 3'd1, 3'd1, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SBC, 3'd3, 3'd0, 3'd1, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_CMP, 3'd4, 3'd1, 3'd2, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_CMP, 3'd4, 3'd2, 3'd1, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_CMP, 3'd4, 3'd1, 3'd1, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_AND, 3'd5, 3'd1, 3'd0, MODE_LONG, 16'h7FFF, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_OR, 3'd5, 3'd5, 3'd0, MODE_LONG, 16'h8000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_NOT, 3'd2, 3'd5, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SHR, 3'd3, 3'd5, 3'd7, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SHL, 3'd3, 3'd5, 3'd0, MODE_LONG, 16'h0021, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SAR, 3'd3, 3'd5, 3'd3, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_ROR, 3'd3, 3'd5, 3'd0, MODE_LONG, 16'h0004, 4'd0), 0, none);
        // word store across the top of memory, then read back in every width
        add_row(mk(REQ_EXEC, OP_SW, 3'd0, 3'd1, 3'd5, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_LW, 3'd4, 3'd1, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SB, 3'd0, 3'd0, 3'd0, MODE_LONG, 16'hFFFF, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_SH, 3'd0, 3'd1, 3'd0, MODE_LONG, 16'h1234, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_LB, 3'd4, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_LH, 3'd4, 3'd1, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_PUSH, 3'd0, 3'd0, 3'd5, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_POP, 3'd3, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_JMP, 3'd0, 3'd1, 3'd0, MODE_LONG, 16'h0040, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_JMP, 3'd0, 3'd0, 3'd0, MODE_LONG, 16'h0400, 4'd0), 0, none);
        // fault, unknown opcode, raise, out-of-range bit index, PC write, no-op
        add_row(mk(REQ_EXEC, OP_ADC, 3'd3, 3'd1, 3'd1, MODE_FAULT, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_BAD_LAST, 3'd4, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_RAISE, OP_NOP, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd15), 0, none);
        add_row(mk(REQ_EXEC, OP_PGET, 3'd2, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_MSET, 3'd0, 3'd1, 3'd1, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_MGET, 3'd5, 3'd1, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_OR, REG_PC, 3'd0, 3'd0, MODE_LONG, 16'h0100, 4'd0), 0, none);
        add_row(mk(REQ_EXEC, OP_NOP, REG_PC, 3'd7, 3'd7, MODE_REG, 16'h0000, 4'd0), 0, none);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);

        // random phases; the first one starts with a long receiver hold-off
        for (int ph = 0; ph < 4; ph++) begin
            traffic = ph;
            if (ph == 0)
                hold_go = 1;
            for (int n = 0; n < RANDOM_REQS / 4; n++) begin
                send_req(random_req(), 0, none);
                // pull PC back down before an advance could reach the halt limit
                if (cpu_regs[REG_PC] >= 32'h0000_C000)
                    send_req(mk(REQ_EXEC, OP_OR, REG_PC, 3'd0, 3'd0, MODE_LONG, 16'h0100,
                                4'd0), 0, none);
            end
        end

        // closing run: wait for an interrupt, enter it, then stay trapped
        traffic = 3;
        send_req(mk(REQ_EXEC, OP_PSET, 3'd0, 3'd0, 3'd0, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_MSET, 3'd0, 3'd0, 3'd1, MODE_SHORT, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_WFI, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_NOP, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_ADC, 3'd1, 3'd1, 3'd1, MODE_REG, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_RAISE, OP_NOP, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_HALT, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        send_req(mk(REQ_EXEC, OP_NOP, 3'd0, 3'd0, 3'd0, MODE_REG, 16'h0000, 4'd0), 0, none);
        push <= 1'b0;
        traffic = 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tce_pkg.sv
rtl/tce_front.sv
rtl/tce_queue.sv
rtl/tce_back.sv
rtl/toy_cpu_execute_core.sv
bench/toy_cpu_execute_core_tb.sv
